### rtl/ptlik_pkg.sv
// shared constants, types and tables of the two-link inverse kinematics pipeline
package ptlik_pkg;

	localparam int CW = 24;
	localparam int FB = 16;
	localparam int LW = 23;
	localparam int NS = 18;
	localparam int AW = 34;
	localparam int VW = 60;
	localparam int RW = 34;
	localparam int DIV_N = FB + 1;
	localparam int DRW = 2 * CW + 1;
	localparam int SQ1_N = FB + 1;
	localparam int SQ1W = 2 * FB + 2;
	localparam int SQ2_N = CW + 1;
	localparam int SQ2W = 2 * CW + 3;
	localparam int PW = LW + FB + 3;
	localparam int ASH = 30 - FB;

	localparam logic [1:0] REG_L1 = 2'd0;
	localparam logic [1:0] REG_L2 = 2'd1;
	localparam logic [1:0] REG_ELB = 2'd2;

	localparam logic signed [AW+1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [AW+1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [AW+1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [RW-1:0] GAIN_INV_Q30 = 34'sd652032874;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic bad;
		logic neg;
		logic signed [FB+1:0] c;
		logic signed [FB+1:0] s;
		logic [2:0] vz;
		logic signed [FB+3:0] q1;
		logic signed [FB+2:0] q2;
		logic [1:0] rneg;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
	} ctx_t;

	function automatic logic signed [AW-1:0] atan_q30(input int unsigned i);
		case (i)
			0: return 34'sd843314857;
			1: return 34'sd497837829;
			2: return 34'sd263043837;
			3: return 34'sd133525159;
			4: return 34'sd67021687;
			5: return 34'sd33543516;
			6: return 34'sd16775851;
			7: return 34'sd8388437;
			8: return 34'sd4194283;
			9: return 34'sd2097149;
			10: return 34'sd1048576;
			11: return 34'sd524288;
			12: return 34'sd262144;
			13: return 34'sd131072;
			14: return 34'sd65536;
			15: return 34'sd32768;
			16: return 34'sd16384;
			17: return 34'sd8192;
			18: return 34'sd4096;
			19: return 34'sd2048;
			20: return 34'sd1024;
			21: return 34'sd512;
			22: return 34'sd256;
			23: return 34'sd128;
			24: return 34'sd64;
			25: return 34'sd32;
			26: return 34'sd16;
			27: return 34'sd8;
			default: return '0;
		endcase
	endfunction

	// left shift that brings the leading one to bit 55
	function automatic logic [5:0] norm_shift(input logic [55:0] m);
		logic [5:0] msb;
		msb = '0;
		for (int i = 0; i < 56; i++) begin
			if (m[i]) msb = 6'(i);
		end
		return 6'd55 - msb;
	endfunction

endpackage

### rtl/ptlik_div_cell.sv
// one restoring division step: compare, subtract, shift in a quotient bit
module ptlik_div_cell #(
	parameter int RWD = 49,
	parameter int QW = 17
) (
	input logic clk,
	input logic en,
	input logic [RWD-1:0] rem_i,
	input logic [RWD-1:0] den_i,
	input logic [QW-1:0] quo_i,
	output logic [RWD-1:0] rem_o,
	output logic [RWD-1:0] den_o,
	output logic [QW-1:0] quo_o
);
	logic ge;
	assign ge = rem_i >= den_i;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? rem_i - den_i : rem_i;
			den_o <= den_i;
			quo_o <= {quo_i[QW-2:0], ge};
		end
	end
endmodule

### rtl/ptlik_sqrt_cell.sv
// one digit step of the integer square root
module ptlik_sqrt_cell #(
	parameter int NW = 34,
	parameter int BIT = 0
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] n_i,
	input logic [NW-1:0] r_i,
	output logic [NW-1:0] n_o,
	output logic [NW-1:0] r_o
);
	logic [NW-1:0] bitv, t;
	logic ge;
	assign bitv = NW'(1) << BIT;
	assign t = r_i + bitv;
	assign ge = n_i >= t;

	always_ff @(posedge clk) begin
		if (en) begin
			n_o <= ge ? n_i - t : n_i;
			r_o <= ge ? (r_i >> 1) + bitv : r_i >> 1;
		end
	end
endmodule

### rtl/ptlik_cordic_cell.sv
// one cordic micro-rotation, vectoring or rotation mode
module ptlik_cordic_cell import ptlik_pkg::*; #(
	parameter int W = 60,
	parameter int IDX = 0,
	parameter bit VEC = 1'b1
) (
	input logic clk,
	input logic en,
	input logic signed [W-1:0] x_i,
	input logic signed [W-1:0] y_i,
	input logic signed [AW-1:0] z_i,
	output logic signed [W-1:0] x_o,
	output logic signed [W-1:0] y_o,
	output logic signed [AW-1:0] z_o
);
	logic signed [W-1:0] dx, dy;
	logic ccw;
	assign dx = y_i >>> IDX;
	assign dy = x_i >>> IDX;
	assign ccw = VEC ? y_i[W-1] : ~z_i[AW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_o <= x_i - dx;
				y_o <= y_i + dy;
				z_o <= z_i - atan_q30(IDX);
			end else begin
				x_o <= x_i + dx;
				y_o <= y_i - dy;
				z_o <= z_i + atan_q30(IDX);
			end
		end
	end
endmodule

### rtl/planar_two_link_inverse_kinematics.sv
// Closed-form inverse kinematics of a planar two-link arm, one target per beat.
// Input stream: s_tdata carries target_x and target_y (signed Q7.16).
// Output stream: m_tuser is the reachable flag, m_tdata the angles (shoulder Q3.16,
// elbow Q2.16), the forward-kinematics point and its distance to the target.
// Link lengths and the elbow branch sit in APB registers at 0x0, 0x4 and 0x8;
// write them only while no beat is in flight.
// The datapath holds a restoring divider for cos(q2), a root for sin(q2),
// three parallel vectoring cordics, two rotating cordics and a root for the
// error, each a chain of registered cells. One beat is taken every cycle
// while the output is not stalled. All stages move together; when the output
// beat is not taken the whole pipeline holds and s_tready drops.
// Reset clears every valid bit and loads the register defaults; an
// unreachable target gives reachable low and all other fields zero.
module planar_two_link_inverse_kinematics import ptlik_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata,   // target_x, target_y
	output logic m_tvalid,
	input logic m_tready,
	output logic [111:0] m_tdata, // shoulder_angle, elbow_angle, reached_x, reached_y, position_error
	output logic m_tuser          // reachable
);
	localparam logic [FB:0] ONE = 17'd65536;
	localparam logic signed [AW+1:0] RND_A = 36'sd1 <<< (29 - FB);
	localparam logic signed [RW+LW+1:0] RND_C = 59'sd1 <<< 29;
	localparam logic signed [RW+LW+1:0] C_HI = (59'sd1 <<< (CW - 1)) - 59'sd1;
	localparam logic signed [RW+LW+1:0] C_LO = -(59'sd1 <<< (CW - 1));

	logic [LW-1:0] l1_q, l2_q;
	logic elb_q;
	logic wr, adv, acc;
	logic vo_q;

	// config
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l1_q <= 23'd32768;
			l2_q <= 23'd26214;
			elb_q <= 1'b1;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_L1: l1_q <= pwdata[LW-1:0];
				REG_L2: l2_q <= pwdata[LW-1:0];
				REG_ELB: elb_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_L1: prdata = {9'b0, l1_q};
			REG_L2: prdata = {9'b0, l2_q};
			REG_ELB: prdata = {31'b0, elb_q};
			default: prdata = '0;
		endcase
	end

	assign adv = ~vo_q | m_tready;
	assign s_tready = adv;
	assign acc = s_tvalid & adv;

	// law of cosines front end
	logic signed [CW-1:0] xin, yin;
	assign xin = s_tdata[CW-1:0];
	assign yin = s_tdata[2*CW-1:CW];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, v_s19;
	ctx_t cx_s1, cx_s2, cx_s3, cx_s4, cx_s5, cx_s6, cx_s7, cx_s8, cx_s9, cx_s10;
	ctx_t cx_s11, cx_s12, cx_s13, cx_s14, cx_s15, cx_s16, cx_s17, cx_s18, cx_s19;

	logic signed [2*CW-1:0] xx_s1, yy_s1;
	logic [2*LW-1:0] l1sq_s1, l2sq_s1, l12_s1;
	logic [2*CW:0] r2_s2;
	logic [2*LW:0] ls_s2, d_s2;
	logic zl_s2;
	logic [DRW-1:0] mag_s3, den_s3;

	ctx_t cx_in;
	always_comb begin
		cx_in = '0;
		cx_in.x = xin;
		cx_in.y = yin;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s1 <= cx_in;
			xx_s1 <= xin * xin;
			yy_s1 <= yin * yin;
			l1sq_s1 <= l1_q * l1_q;
			l2sq_s1 <= l2_q * l2_q;
			l12_s1 <= l1_q * l2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s2 <= cx_s1;
			r2_s2 <= DRW'($unsigned(xx_s1)) + DRW'($unsigned(yy_s1));
			ls_s2 <= (2*LW+1)'(l1sq_s1) + (2*LW+1)'(l2sq_s1);
			d_s2 <= {l12_s1, 1'b0};
			zl_s2 <= (l1_q == '0) | (l2_q == '0);
		end
	end

	logic neg3;
	logic [DRW-1:0] mag3, ls3;
	assign ls3 = DRW'(ls_s2);
	assign neg3 = r2_s2 < ls3;
	assign mag3 = neg3 ? ls3 - r2_s2 : r2_s2 - ls3;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s3 <= cx_s2;
			cx_s3.neg <= neg3;
			cx_s3.bad <= zl_s2 | (mag3 >= DRW'({d_s2, 1'b0}));
			mag_s3 <= mag3;
			den_s3 <= DRW'(d_s2);
		end
	end

	// divider chain for |cos(q2)|
	logic [DRW-1:0] dv_rem [DIV_N];
	logic [DRW-1:0] dv_den [DIV_N];
	logic [DIV_N-1:0] dv_quo [DIV_N];
	ctx_t dv_cx [DIV_N];
	logic [DIV_N-1:0] dv_v;

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic [DRW-1:0] rin, din;
		logic [DIV_N-1:0] qin;
		ctx_t cin;
		logic vin;
		if (k == 0) begin : g_first
			assign rin = mag_s3;
			assign din = den_s3;
			assign qin = '0;
			assign cin = cx_s3;
			assign vin = v_s3;
		end else begin : g_next
			assign rin = {dv_rem[k-1][DRW-2:0], 1'b0};
			assign din = dv_den[k-1];
			assign qin = dv_quo[k-1];
			assign cin = dv_cx[k-1];
			assign vin = dv_v[k-1];
		end
		ptlik_div_cell #(.RWD(DRW), .QW(DIV_N)) u_cell (
			.clk(clk), .en(adv), .rem_i(rin), .den_i(din), .quo_i(qin),
			.rem_o(dv_rem[k]), .den_o(dv_den[k]), .quo_o(dv_quo[k])
		);
		always_ff @(posedge clk) begin
			if (adv) dv_cx[k] <= cin;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[k] <= 1'b0;
			else if (adv) dv_v[k] <= vin;
		end
	end

	// clamp and sin radicand
	logic [FB:0] cm4, cmq, cm_s4;
	logic [SQ1W-1:0] rad_s5;
	assign cmq = dv_quo[DIV_N-1];
	assign cm4 = (cmq > ONE) ? ONE : cmq;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s4 <= dv_cx[DIV_N-1];
			cx_s4.bad <= dv_cx[DIV_N-1].bad | (cmq > ONE + 17'd1);
			cx_s4.c <= dv_cx[DIV_N-1].neg ? -$signed({1'b0, cm4}) : $signed({1'b0, cm4});
			cm_s4 <= cm4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s5 <= cx_s4;
			rad_s5 <= (SQ1W'(1) << (2 * FB)) - SQ1W'(cm_s4 * cm_s4);
		end
	end

	// root chain for |sin(q2)|
	logic [SQ1W-1:0] s1_n [SQ1_N];
	logic [SQ1W-1:0] s1_r [SQ1_N];
	ctx_t s1_cx [SQ1_N];
	logic [SQ1_N-1:0] s1_v;

	for (genvar k = 0; k < SQ1_N; k++) begin : g_sq1
		logic [SQ1W-1:0] nin, rin;
		ctx_t cin;
		logic vin;
		if (k == 0) begin : g_first
			assign nin = rad_s5;
			assign rin = '0;
			assign cin = cx_s5;
			assign vin = v_s5;
		end else begin : g_next
			assign nin = s1_n[k-1];
			assign rin = s1_r[k-1];
			assign cin = s1_cx[k-1];
			assign vin = s1_v[k-1];
		end
		ptlik_sqrt_cell #(.NW(SQ1W), .BIT(2 * (FB - k))) u_cell (
			.clk(clk), .en(adv), .n_i(nin), .r_i(rin), .n_o(s1_n[k]), .r_o(s1_r[k])
		);
		always_ff @(posedge clk) begin
			if (adv) s1_cx[k] <= cin;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) s1_v[k] <= 1'b0;
			else if (adv) s1_v[k] <= vin;
		end
	end

	// branch, elbow vector
	logic signed [FB+1:0] sabs;
	logic signed [PW-1:0] ps_s7, pc_s7;
	logic signed [PW:0] vx_s8, vy_s8;
	assign sabs = $signed(s1_r[SQ1_N-1][FB+1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s6 <= s1_cx[SQ1_N-1];
			cx_s6.s <= elb_q ? sabs : -sabs;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s7 <= cx_s6;
			ps_s7 <= $signed({1'b0, l2_q}) * cx_s6.s;
			pc_s7 <= $signed({1'b0, l2_q}) * cx_s6.c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s8 <= cx_s7;
			vx_s8 <= $signed({1'b0, l1_q, {FB{1'b0}}}) + pc_s7;
			vy_s8 <= ps_s7;
		end
	end

	// vectoring front end: normalize and fold into the right half plane
	logic signed [VW-1:0] vin_x [3];
	logic signed [VW-1:0] vin_y [3];
	logic signed [VW-1:0] vx_s9 [3];
	logic signed [VW-1:0] vy_s9 [3];
	logic [5:0] sh_s9 [3];
	logic [2:0] zr9;
	logic signed [VW-1:0] vcx0 [3];
	logic signed [VW-1:0] vcy0 [3];
	logic signed [AW-1:0] vcz0 [3];

	assign vin_x[0] = cx_s8.c;
	assign vin_y[0] = cx_s8.s;
	assign vin_x[1] = cx_s8.x;
	assign vin_y[1] = cx_s8.y;
	assign vin_x[2] = vx_s8;
	assign vin_y[2] = vy_s8;

	for (genvar u = 0; u < 3; u++) begin : g_vprep
		logic [VW-1:0] mx, my, mm;
		logic signed [VW-1:0] xs, ys;
		assign mx = vin_x[u][VW-1] ? $unsigned(-vin_x[u]) : $unsigned(vin_x[u]);
		assign my = vin_y[u][VW-1] ? $unsigned(-vin_y[u]) : $unsigned(vin_y[u]);
		assign mm = (mx > my) ? mx : my;
		assign zr9[u] = (mm == '0);
		always_ff @(posedge clk) begin
			if (adv) begin
				vx_s9[u] <= vin_x[u];
				vy_s9[u] <= vin_y[u];
				sh_s9[u] <= norm_shift(mm[55:0]);
			end
		end
		assign xs = vx_s9[u] <<< sh_s9[u];
		assign ys = vy_s9[u] <<< sh_s9[u];
		always_ff @(posedge clk) begin
			if (adv) begin
				if (xs[VW-1] && !ys[VW-1]) begin
					vcx0[u] <= ys;
					vcy0[u] <= -xs;
					vcz0[u] <= AW'(HALF_PI_Q30);
				end else if (xs[VW-1]) begin
					vcx0[u] <= -ys;
					vcy0[u] <= xs;
					vcz0[u] <= -AW'(HALF_PI_Q30);
				end else begin
					vcx0[u] <= xs;
					vcy0[u] <= ys;
					vcz0[u] <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s9 <= cx_s8;
			cx_s9.vz <= zr9;
			cx_s10 <= cx_s9;
		end
	end

	// three vectoring cordics side by side
	logic signed [VW-1:0] vc_x [3][NS];
	logic signed [VW-1:0] vc_y [3][NS];
	logic signed [AW-1:0] vc_z [3][NS];
	ctx_t vc_cx [NS];
	logic [NS-1:0] vc_v;

	for (genvar k = 0; k < NS; k++) begin : g_vec
		ctx_t cin;
		logic vin;
		if (k == 0) begin : g_first
			assign cin = cx_s10;
			assign vin = v_s10;
		end else begin : g_next
			assign cin = vc_cx[k-1];
			assign vin = vc_v[k-1];
		end
		for (genvar u = 0; u < 3; u++) begin : g_unit
			logic signed [VW-1:0] xi, yi;
			logic signed [AW-1:0] zi;
			if (k == 0) begin : g_first
				assign xi = vcx0[u];
				assign yi = vcy0[u];
				assign zi = vcz0[u];
			end else begin : g_next
				assign xi = vc_x[u][k-1];
				assign yi = vc_y[u][k-1];
				assign zi = vc_z[u][k-1];
			end
			ptlik_cordic_cell #(.W(VW), .IDX(k), .VEC(1'b1)) u_cell (
				.clk(clk), .en(adv), .x_i(xi), .y_i(yi), .z_i(zi),
				.x_o(vc_x[u][k]), .y_o(vc_y[u][k]), .z_o(vc_z[u][k])
			);
		end
		always_ff @(posedge clk) begin
			if (adv) vc_cx[k] <= cin;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vc_v[k] <= 1'b0;
			else if (adv) vc_v[k] <= vin;
		end
	end

	// joint angles
	ctx_t vce;
	logic signed [AW+1:0] za, z1, z2, q1w, q2w;
	assign vce = vc_cx[NS-1];
	assign za = vce.vz[0] ? '0 : vc_z[0][NS-1];
	assign z1 = vce.vz[1] ? '0 : vc_z[1][NS-1];
	assign z2 = vce.vz[2] ? '0 : vc_z[2][NS-1];
	assign q1w = (z1 - z2 + RND_A) >>> ASH;
	assign q2w = (za + RND_A) >>> ASH;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s11 <= vce;
			cx_s11.q1 <= q1w[FB+3:0];
			cx_s11.q2 <= q2w[FB+2:0];
		end
	end

	// rotation front end: wrap to (-pi, pi], fold to the right half
	logic signed [AW+1:0] ra [2];
	logic signed [AW+1:0] a_s12 [2];
	logic signed [AW-1:0] rz_s13 [2];
	logic [1:0] rn13;
	logic signed [AW+1:0] q1e, q2e;
	assign q1e = cx_s11.q1;
	assign q2e = cx_s11.q2;
	assign ra[0] = q1e <<< ASH;
	assign ra[1] = (q1e + q2e) <<< ASH;

	for (genvar u = 0; u < 2; u++) begin : g_rprep
		always_ff @(posedge clk) begin
			if (adv) begin
				if (ra[u] > PI_Q30) a_s12[u] <= ra[u] - TWO_PI_Q30;
				else if (ra[u] <= -PI_Q30) a_s12[u] <= ra[u] + TWO_PI_Q30;
				else a_s12[u] <= ra[u];
			end
		end
		assign rn13[u] = (a_s12[u] > HALF_PI_Q30) | (a_s12[u] < -HALF_PI_Q30);
		always_ff @(posedge clk) begin
			if (adv) begin
				if (a_s12[u] > HALF_PI_Q30) rz_s13[u] <= AW'(a_s12[u] - PI_Q30);
				else if (a_s12[u] < -HALF_PI_Q30) rz_s13[u] <= AW'(a_s12[u] + PI_Q30);
				else rz_s13[u] <= AW'(a_s12[u]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s12 <= cx_s11;
			cx_s13 <= cx_s12;
			cx_s13.rneg <= rn13;
		end
	end

	// two rotating cordics
	logic signed [RW-1:0] rc_x [2][NS];
	logic signed [RW-1:0] rc_y [2][NS];
	logic signed [AW-1:0] rc_z [2][NS];
	ctx_t rc_cx [NS];
	logic [NS-1:0] rc_v;

	for (genvar k = 0; k < NS; k++) begin : g_rot
		ctx_t cin;
		logic vin;
		if (k == 0) begin : g_first
			assign cin = cx_s13;
			assign vin = v_s13;
		end else begin : g_next
			assign cin = rc_cx[k-1];
			assign vin = rc_v[k-1];
		end
		for (genvar u = 0; u < 2; u++) begin : g_unit
			logic signed [RW-1:0] xi, yi;
			logic signed [AW-1:0] zi;
			if (k == 0) begin : g_first
				assign xi = GAIN_INV_Q30;
				assign yi = '0;
				assign zi = rz_s13[u];
			end else begin : g_next
				assign xi = rc_x[u][k-1];
				assign yi = rc_y[u][k-1];
				assign zi = rc_z[u][k-1];
			end
			ptlik_cordic_cell #(.W(RW), .IDX(k), .VEC(1'b0)) u_cell (
				.clk(clk), .en(adv), .x_i(xi), .y_i(yi), .z_i(zi),
				.x_o(rc_x[u][k]), .y_o(rc_y[u][k]), .z_o(rc_z[u][k])
			);
		end
		always_ff @(posedge clk) begin
			if (adv) rc_cx[k] <= cin;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rc_v[k] <= 1'b0;
			else if (adv) rc_v[k] <= vin;
		end
	end

	// forward kinematics
	logic signed [RW-1:0] cs_s14 [4];
	logic signed [RW+LW:0] pr_s15 [4];
	logic signed [RW+LW+1:0] sxr, syr;
	logic signed [CW-1:0] ax16, ay16;
	ctx_t rce;
	assign rce = rc_cx[NS-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s14 <= rce;
			cs_s14[0] <= rce.rneg[0] ? -rc_x[0][NS-1] : rc_x[0][NS-1];
			cs_s14[1] <= rce.rneg[0] ? -rc_y[0][NS-1] : rc_y[0][NS-1];
			cs_s14[2] <= rce.rneg[1] ? -rc_x[1][NS-1] : rc_x[1][NS-1];
			cs_s14[3] <= rce.rneg[1] ? -rc_y[1][NS-1] : rc_y[1][NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s15 <= cx_s14;
			pr_s15[0] <= $signed({1'b0, l1_q}) * cs_s14[0];
			pr_s15[1] <= $signed({1'b0, l1_q}) * cs_s14[1];
			pr_s15[2] <= $signed({1'b0, l2_q}) * cs_s14[2];
			pr_s15[3] <= $signed({1'b0, l2_q}) * cs_s14[3];
		end
	end

	assign sxr = (pr_s15[0] + pr_s15[2] + RND_C) >>> 30;
	assign syr = (pr_s15[1] + pr_s15[3] + RND_C) >>> 30;
	assign ax16 = (sxr > C_HI) ? CW'(C_HI) : ((sxr < C_LO) ? CW'(C_LO) : sxr[CW-1:0]);
	assign ay16 = (syr > C_HI) ? CW'(C_HI) : ((syr < C_LO) ? CW'(C_LO) : syr[CW-1:0]);

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s16 <= cx_s15;
			cx_s16.ax <= ax16;
			cx_s16.ay <= ay16;
		end
	end

	// error distance
	logic signed [CW:0] dx_s17, dy_s17;
	logic signed [2*CW+1:0] ex_s18, ey_s18;
	logic [SQ2W-1:0] sum_s19;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_s17 <= cx_s16;
			dx_s17 <= (CW+1)'(cx_s16.ax) - (CW+1)'(cx_s16.x);
			dy_s17 <= (CW+1)'(cx_s16.ay) - (CW+1)'(cx_s16.y);
			cx_s18 <= cx_s17;
			ex_s18 <= dx_s17 * dx_s17;
			ey_s18 <= dy_s17 * dy_s17;
			cx_s19 <= cx_s18;
			sum_s19 <= SQ2W'($unsigned(ex_s18)) + SQ2W'($unsigned(ey_s18));
		end
	end

	logic [SQ2W-1:0] s2_n [SQ2_N];
	logic [SQ2W-1:0] s2_r [SQ2_N];
	ctx_t s2_cx [SQ2_N];
	logic [SQ2_N-1:0] s2_v;

	for (genvar k = 0; k < SQ2_N; k++) begin : g_sq2
		logic [SQ2W-1:0] nin, rin;
		ctx_t cin;
		logic vin;
		if (k == 0) begin : g_first
			assign nin = sum_s19;
			assign rin = '0;
			assign cin = cx_s19;
			assign vin = v_s19;
		end else begin : g_next
			assign nin = s2_n[k-1];
			assign rin = s2_r[k-1];
			assign cin = s2_cx[k-1];
			assign vin = s2_v[k-1];
		end
		ptlik_sqrt_cell #(.NW(SQ2W), .BIT(2 * (CW - k))) u_cell (
			.clk(clk), .en(adv), .n_i(nin), .r_i(rin), .n_o(s2_n[k]), .r_o(s2_r[k])
		);
		always_ff @(posedge clk) begin
			if (adv) s2_cx[k] <= cin;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) s2_v[k] <= 1'b0;
			else if (adv) s2_v[k] <= vin;
		end
	end

	// output register
	ctx_t ce;
	logic [CW-1:0] err;
	logic reach_q;
	logic [FB+3:0] q1_q;
	logic [FB+2:0] q2_q;
	logic [CW-1:0] ax_q, ay_q, err_q;
	assign ce = s2_cx[SQ2_N-1];
	assign err = (s2_r[SQ2_N-1] > SQ2W'({CW{1'b1}})) ? {CW{1'b1}} : s2_r[SQ2_N-1][CW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			reach_q <= ~ce.bad;
			q1_q <= ce.bad ? '0 : ce.q1;
			q2_q <= ce.bad ? '0 : ce.q2;
			ax_q <= ce.bad ? '0 : ce.ax;
			ay_q <= ce.bad ? '0 : ce.ay;
			err_q <= ce.bad ? '0 : err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0; v_s19 <= 1'b0;
			vo_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= dv_v[DIV_N-1]; v_s5 <= v_s4;
			v_s6 <= s1_v[SQ1_N-1]; v_s7 <= v_s6; v_s8 <= v_s7; v_s9 <= v_s8; v_s10 <= v_s9;
			v_s11 <= vc_v[NS-1]; v_s12 <= v_s11; v_s13 <= v_s12;
			v_s14 <= rc_v[NS-1]; v_s15 <= v_s14; v_s16 <= v_s15;
			v_s17 <= v_s16; v_s18 <= v_s17; v_s19 <= v_s18;
			vo_q <= s2_v[SQ2_N-1];
		end
	end

	assign m_tvalid = vo_q;
	assign m_tuser = reach_q;
	assign m_tdata = {1'b0, err_q, ay_q, ax_q, q2_q, q1_q};

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("unreachable beat carries nonzero fields");

	a_elbow_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> ($signed(m_tdata[38:20]) <= 19'sd205887) &&
			($signed(m_tdata[38:20]) >= -19'sd205887))
		else $error("elbow angle outside plus or minus pi");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

endmodule
